// ===== sv/rope_pkg.sv =====
package rope_pkg;

  localparam int HEAD_DIM_DEF = 128;
  localparam int ROM_DEPTH    = 64;
  localparam int POS_W        = 12;
  localparam int PAIR_W       = 6;
  localparam int X_W          = 16;

  // exp() series for the step table, sin/cos series in the datapath
  localparam int EXP_TERMS  = 16;
  localparam int TRIG_TERMS = 18;

  localparam longint unsigned LN10K_Q32  = 64'd39558110683;
  localparam longint unsigned LN2_Q32    = 64'd2977044472;
  localparam longint unsigned TURN_SCALE = 64'd683565276;
  localparam longint unsigned ONE_Q32    = 64'd4294967296;

  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30    = 31'd1073741824;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic        [POS_W-1:0]  position;
    logic        [PAIR_W-1:0] pair_index;
    logic signed [X_W-1:0]    x_even;
    logic signed [X_W-1:0]    x_odd;
  } rope_in_t;

  typedef struct packed {
    logic signed [X_W-1:0] y_even;
    logic signed [X_W-1:0] y_odd;
  } rope_out_t;

  // travels alongside the angle through the sin/cos pipeline
  typedef struct packed {
    quad_t                 quad;
    logic signed [X_W-1:0] x_even;
    logic signed [X_W-1:0] x_odd;
  } rope_side_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [32:0] recip_q32(input int k);
    logic [32:0] m;
    case (k)
      1:       m = 33'(ONE_Q32);
      2:       m = 33'(ONE_Q32 / 2);
      3:       m = 33'(ONE_Q32 / 3);
      4:       m = 33'(ONE_Q32 / 4);
      5:       m = 33'(ONE_Q32 / 5);
      6:       m = 33'(ONE_Q32 / 6);
      7:       m = 33'(ONE_Q32 / 7);
      8:       m = 33'(ONE_Q32 / 8);
      9:       m = 33'(ONE_Q32 / 9);
      10:      m = 33'(ONE_Q32 / 10);
      11:      m = 33'(ONE_Q32 / 11);
      12:      m = 33'(ONE_Q32 / 12);
      13:      m = 33'(ONE_Q32 / 13);
      14:      m = 33'(ONE_Q32 / 14);
      15:      m = 33'(ONE_Q32 / 15);
      16:      m = 33'(ONE_Q32 / 16);
      17:      m = 33'(ONE_Q32 / 17);
      18:      m = 33'(ONE_Q32 / 18);
      default: m = '0;
    endcase
    return m;
  endfunction

  // exact floor(p / k) for p below 2^32: reciprocal estimate, one correction
  function automatic longint unsigned div_small(input longint unsigned p, input int k);
    longint unsigned q;
    longint unsigned kk;
    kk = 64'(k);
    q  = (p * 64'(recip_q32(k))) >> 32;
    if (p - q * kk >= kk) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

// ===== sv/rope_sincos.sv =====
module rope_sincos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [30:0]         in_a,
  input  rope_pkg::rope_side_t in_side,
  output logic                out_valid,
  output logic signed [31:0]  out_sin,
  output logic signed [31:0]  out_cos,
  output rope_pkg::rope_side_t out_side
);
  import rope_pkg::*;

  // three stages per series term after the first: a*t, reciprocal, correct+accumulate
  localparam int NSTG = 3 * (TRIG_TERMS - 1);

  typedef struct packed {
    logic        [30:0] a;
    logic        [30:0] t;
    logic        [31:0] p;
    logic        [31:0] q;
    logic signed [32:0] s;
    logic signed [32:0] c;
    rope_side_t         side;
  } term_t;

  term_t        stg_r   [NSTG+1];
  term_t        stg_nxt [NSTG+1];
  logic [NSTG:0] vld_r;

  logic               out_vld_r;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;
  rope_side_t         side_r;
  logic signed [31:0] sin_nxt;
  logic signed [31:0] cos_nxt;
  logic        [30:0] s_cl;
  logic        [30:0] c_cl;

  // first term of each series is taken at entry: s = a, c = 1
  always_comb begin
    stg_nxt[0].a    = in_a;
    stg_nxt[0].t    = in_a;
    stg_nxt[0].p    = '0;
    stg_nxt[0].q    = '0;
    stg_nxt[0].s    = signed'({2'b00, in_a});
    stg_nxt[0].c    = signed'({2'b00, ONE_Q30});
    stg_nxt[0].side = in_side;
  end

  for (genvar j = 1; j <= NSTG; j++) begin : g_stg
    localparam int K   = (j - 1) / 3 + 2;
    localparam int SUB = (j - 1) % 3;
    localparam int KM  = K % 4;
    localparam logic [31:0] M = 32'(recip_q32(K));

    if (SUB == 0) begin : g_mul
      logic [61:0] prod;
      assign prod = 62'(stg_r[j-1].t) * 62'(stg_r[j-1].a);
      always_comb begin
        stg_nxt[j]   = stg_r[j-1];
        stg_nxt[j].p = prod[61:30];
      end
    end else if (SUB == 1) begin : g_rcp
      logic [63:0] qprod;
      assign qprod = 64'(stg_r[j-1].p) * 64'(M);
      always_comb begin
        stg_nxt[j]   = stg_r[j-1];
        stg_nxt[j].q = qprod[63:32];
      end
    end else begin : g_acc
      logic        [31:0] rem;
      logic        [31:0] tk;
      logic signed [32:0] tt;
      // estimate is at most one low
      assign rem = stg_r[j-1].p - stg_r[j-1].q * 32'(K);
      assign tk  = (rem >= 32'(K)) ? stg_r[j-1].q + 32'd1 : stg_r[j-1].q;
      assign tt  = signed'({2'b00, tk[30:0]});
      always_comb begin
        stg_nxt[j]   = stg_r[j-1];
        stg_nxt[j].t = tk[30:0];
        case (KM)
          1:       stg_nxt[j].s = stg_r[j-1].s + tt;
          2:       stg_nxt[j].c = stg_r[j-1].c - tt;
          3:       stg_nxt[j].s = stg_r[j-1].s - tt;
          default: stg_nxt[j].c = stg_r[j-1].c + tt;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= NSTG; j++) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  // clamp to [0, 1] and place by quadrant
  always_comb begin
    if (stg_r[NSTG].s < 0) begin
      s_cl = '0;
    end else if (stg_r[NSTG].s > signed'({2'b00, ONE_Q30})) begin
      s_cl = ONE_Q30;
    end else begin
      s_cl = stg_r[NSTG].s[30:0];
    end
    if (stg_r[NSTG].c < 0) begin
      c_cl = '0;
    end else if (stg_r[NSTG].c > signed'({2'b00, ONE_Q30})) begin
      c_cl = ONE_Q30;
    end else begin
      c_cl = stg_r[NSTG].c[30:0];
    end
    case (stg_r[NSTG].side.quad)
      QUAD_0: begin
        sin_nxt = signed'({1'b0, s_cl});
        cos_nxt = signed'({1'b0, c_cl});
      end
      QUAD_1: begin
        sin_nxt = signed'({1'b0, c_cl});
        cos_nxt = -signed'({1'b0, s_cl});
      end
      QUAD_2: begin
        sin_nxt = -signed'({1'b0, s_cl});
        cos_nxt = -signed'({1'b0, c_cl});
      end
      default: begin
        sin_nxt = -signed'({1'b0, c_cl});
        cos_nxt = signed'({1'b0, s_cl});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r  <= sin_nxt;
      cos_r  <= cos_nxt;
      side_r <= stg_r[NSTG].side;
    end
  end

  assign out_valid = out_vld_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;
  assign out_side  = side_r;

endmodule

// ===== sv/rotary_position_embedding.sv =====
// Channel  Ports                            Payload
// input    in_valid, in_ready, in_data      position, pair_index, x_even, x_odd
// output   out_valid, out_ready, out_data   y_even, y_odd
//
// One transfer per cycle in and out while the skid register is empty. Between
// the input transfer and out_valid lie 3 stages for lookup, angle and radians,
// the sin/cos series (an entry register, then three per term after the first),
// the quadrant fix-up, the products and the output register.
// Synchronous active-low reset clears all valid bits; the step table is constant.
// A full skid register behind the output register drops in_ready and freezes the
// whole pipeline; in_ready comes straight from that register.
module rotary_position_embedding #(
  parameter int HEAD_DIM = rope_pkg::HEAD_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rope_pkg::rope_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rope_pkg::rope_out_t out_data
);
  import rope_pkg::*;

  typedef logic [ROM_DEPTH-1:0][31:0] step_rom_t;

  // per-pair phase step in turns, Q32
  function automatic logic [31:0] step_for_pair(input int i);
    longint unsigned x;
    longint unsigned n;
    longint unsigned r;
    longint unsigned t;
    longint unsigned prod;
    longint unsigned s;
    longint          acc;
    x = (64'(2 * i) * LN10K_Q32) / HEAD_DIM;
    n = x / LN2_Q32;
    if (n > 64'd31) begin
      return 32'd0;
    end
    r   = x - n * LN2_Q32;
    t   = ONE_Q32;
    acc = longint'(ONE_Q32);
    for (int k = 1; k <= EXP_TERMS; k++) begin
      t = div_small((t * r) >> 32, k);
      if (k % 2 == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q32)) begin
      acc = longint'(ONE_Q32);
    end
    prod = TURN_SCALE * 64'(acc);
    s    = (prod + (64'd1 << (n + 64'd31))) >> (n + 64'd32);
    if (s > 64'hFFFF_FFFF) begin
      s = 64'hFFFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic step_rom_t build_rom();
    step_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = step_for_pair(i);
    end
    return rom;
  endfunction

  localparam step_rom_t STEP_ROM = build_rom();

  function automatic logic signed [15:0] round_sat(input logic signed [48:0] v);
    logic signed [48:0] b;
    logic signed [18:0] q;
    logic signed [15:0] y;
    b = v + 49'sd536870912;
    q = b[48:30];
    if (q > 19'sd32767) begin
      y = 16'sd32767;
    end else if (q < -19'sd32768) begin
      y = -16'sd32768;
    end else begin
      y = q[15:0];
    end
    return y;
  endfunction

  logic en;

  // stage 0: table lookup
  logic                  s0_vld_r;
  logic [POS_W-1:0]      s0_pos_r;
  logic [31:0]           s0_step_r;
  logic signed [X_W-1:0] s0_xe_r;
  logic signed [X_W-1:0] s0_xo_r;

  // stage 1: angle in turns
  logic                  s1_vld_r;
  logic [31:0]           s1_theta_r;
  logic signed [X_W-1:0] s1_xe_r;
  logic signed [X_W-1:0] s1_xo_r;
  logic [43:0]           theta_prod;

  // stage 2: radians within the quadrant, Q30
  logic                  s2_vld_r;
  logic [30:0]           s2_a_r;
  rope_side_t            s2_side_r;
  logic [60:0]           a_prod;

  logic                  sc_vld;
  logic signed [31:0]    sc_sin;
  logic signed [31:0]    sc_cos;
  rope_side_t            sc_side;

  // stage 3: products
  logic                  p3_vld_r;
  logic signed [47:0]    p3_ec_r;
  logic signed [47:0]    p3_os_r;
  logic signed [47:0]    p3_oc_r;
  logic signed [47:0]    p3_es_r;

  rope_out_t             res;
  logic                  out_vld_r;
  rope_out_t             out_data_r;
  logic                  skid_vld_r;
  rope_out_t             skid_data_r;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  assign theta_prod = 44'(s0_pos_r) * 44'(s0_step_r);
  assign a_prod     = 61'(s1_theta_r[29:0]) * 61'(TWO_PI_Q28);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      p3_vld_r <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pos_r  <= in_data.position;
      s0_step_r <= STEP_ROM[in_data.pair_index];
      s0_xe_r   <= in_data.x_even;
      s0_xo_r   <= in_data.x_odd;

      s1_theta_r <= theta_prod[31:0];
      s1_xe_r    <= s0_xe_r;
      s1_xo_r    <= s0_xo_r;

      s2_a_r           <= a_prod[60:30];
      s2_side_r.quad   <= quad_t'(s1_theta_r[31:30]);
      s2_side_r.x_even <= s1_xe_r;
      s2_side_r.x_odd  <= s1_xo_r;

      p3_ec_r <= 48'(sc_side.x_even) * 48'(sc_cos);
      p3_os_r <= 48'(sc_side.x_odd) * 48'(sc_sin);
      p3_oc_r <= 48'(sc_side.x_odd) * 48'(sc_cos);
      p3_es_r <= 48'(sc_side.x_even) * 48'(sc_sin);
    end
  end

  rope_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .in_a      (s2_a_r),
    .in_side   (s2_side_r),
    .out_valid (sc_vld),
    .out_sin   (sc_sin),
    .out_cos   (sc_cos),
    .out_side  (sc_side)
  );

  assign res.y_even = round_sat(49'(p3_ec_r) - 49'(p3_os_r));
  assign res.y_odd  = round_sat(49'(p3_oc_r) + 49'(p3_es_r));

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ready) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= p3_vld_r;
    end else if (p3_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_vld_r || out_ready) begin
      out_data_r <= res;
    end else begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/rotary_position_embedding_tb.sv =====
module rotary_position_embedding_tb;
  import rope_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 950;
  localparam int DRAIN_CYCLES  = 70;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_IDLE      = 16;
  localparam int REPORT_MAX    = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  rope_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  rope_out_t out_data;

  rotary_position_embedding u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // predictor state: turn fraction per pair
  logic [31:0] step_rom [ROM_DEPTH];

  rope_out_t expected_pairs[$];

  typedef struct {
    rope_in_t  stim;
    bit        typed;
    rope_out_t want;
  } row_t;
  row_t directed_rows[$];

  int  mismatch_count;
  int  items_sent;
  int  results_seen;
  int  saturated_seen;
  int  cycles;
  bit  hold_req;
  bit  tx_gapless;
  bit  rx_gapless;

  function automatic logic [31:0] phase_step_for_pair(input int unsigned i);
    longint unsigned x, n, r, t, prod, s;
    longint acc;
    x = (64'd2 * 64'(i) * LN10K_Q32) / 64'(HEAD_DIM_DEF);
    n = x / LN2_Q32;
    if (n > 31) return 32'd0;
    r = x - n * LN2_Q32;
    t = ONE_Q32;
    acc = longint'(ONE_Q32);
    for (int k = 1; k <= EXP_TERMS; k++) begin
      t = ((t * r) >> 32) / 64'(k);
      if (k % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q32)) acc = longint'(ONE_Q32);
    prod = TURN_SCALE * longint'(acc);
    s = (prod + (64'd1 << (31 + n))) >> (32 + n);
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return s[31:0];
  endfunction

  function automatic void sin_cos_q30(input logic [31:0] theta,
                                      output longint sn, output longint cs);
    quad_t           q;
    longint unsigned a, t;
    longint          s, c, one;
    q   = quad_t'(theta[31:30]);
    one = longint'(ONE_Q30);
    a   = (64'(theta[29:0]) * 64'(TWO_PI_Q28)) >> 30;
    t   = 64'(ONE_Q30);
    s   = 0;
    c   = one;
    for (int k = 1; k <= TRIG_TERMS; k++) begin
      t = ((t * a) >> 30) / 64'(k);
      case (k % 4)
        1: s += longint'(t);
        2: c -= longint'(t);
        3: s -= longint'(t);
        default: c += longint'(t);
      endcase
    end
    if (s < 0) s = 0;
    if (s > one) s = one;
    if (c < 0) c = 0;
    if (c > one) c = one;
    case (q)
      QUAD_0: begin sn = s;  cs = c;  end
      QUAD_1: begin sn = c;  cs = -s; end
      QUAD_2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic signed [15:0] round_sat16(input longint v);
    longint q;
    q = (v + (longint'(1) <<< 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic rope_out_t rotate_pair(input rope_in_t it);
    rope_out_t   r;
    logic [31:0] theta;
    longint      xe, xo, sn, cs;
    longint unsigned wide;
    wide  = 64'(it.position) * 64'(step_rom[it.pair_index]);
    theta = wide[31:0];
    xe    = longint'($signed(it.x_even));
    xo    = longint'($signed(it.x_odd));
    sin_cos_q30(theta, sn, cs);
    r.y_even = round_sat16(xe * cs - xo * sn);
    r.y_odd  = round_sat16(xo * cs + xe * sn);
    return r;
  endfunction

  function automatic logic signed [15:0] pick_x();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(input int pos, input int pair, input int xe, input int xo,
                         input bit typed, input int ye, input int yo);
    row_t r;
    r.stim.position   = POS_W'(pos);
    r.stim.pair_index = PAIR_W'(pair);
    r.stim.x_even     = X_W'(xe);
    r.stim.x_odd      = X_W'(xo);
    r.typed           = typed;
    r.want.y_even     = X_W'(ye);
    r.want.y_odd      = X_W'(yo);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // offer one item after an idle gap and hold it until the transfer
  task automatic send_item(input rope_in_t it, input bit typed, input rope_out_t want,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pairs.insert(expected_pairs.size(), typed ? want : rotate_pair(it));
    items_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    rope_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.y_even == 16'sh7FFF || out_data.y_even == 16'sh8000 ||
          out_data.y_odd == 16'sh7FFF || out_data.y_odd == 16'sh8000) begin
        saturated_seen++;
      end
      if (expected_pairs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result: y_even=%0d y_odd=%0d",
                   $signed(out_data.y_even), $signed(out_data.y_odd));
        end
      end else begin
        want = expected_pairs.pop_front();
        if (out_data.y_even !== want.y_even || out_data.y_odd !== want.y_odd) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result %0d: expected (%0d, %0d), got (%0d, %0d)",
                     results_seen, $signed(want.y_even), $signed(want.y_odd),
                     $signed(out_data.y_even), $signed(out_data.y_odd));
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    int hold_cnt;
    int rx_count;
    out_ready <= 1'b0;
    rx_count = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end else begin
        w = rx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_count++;
      if (rx_count % 64 == 0) rx_gapless = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, expected_pairs.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rope_in_t  it;
    rope_out_t none;
    int        gap;
    int        sel;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    saturated_seen = 0;
    hold_req       = 1'b0;
    tx_gapless     = 1'b0;
    rx_gapless     = 1'b0;
    none           = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    for (int i = 0; i < ROM_DEPTH; i++) step_rom[i] = phase_step_for_pair(i);

    // position zero: no rotation, output equals input
    add_row(0, 0, 0, 0, 1, 0, 0);
    add_row(0, 63, 32767, -32768, 1, 32767, -32768);
    add_row(0, 17, -32768, 32767, 1, -32768, 32767);
    add_row(0, 1, -1, 1, 1, -1, 1);
    add_row(0, 40, 12345, -12345, 1, 12345, -12345);
    // pair 0 turns about one radian per position: walks all quadrants
    add_row(1, 0, 32767, -32768, 0, 0, 0);
    add_row(2, 0, 20000, -20000, 0, 0, 0);
    add_row(3, 0, -32768, -32768, 0, 0, 0);
    add_row(4, 0, -20000, 15000, 0, 0, 0);
    add_row(5, 0, 32767, 0, 0, 0, 0);
    add_row(7, 2, -32768, 32767, 0, 0, 0);
    // top position and top pair with other positions, full-scale and small values
    add_row(4095, 0, 32767, 32767, 0, 0, 0);
    add_row(4095, 63, -32768, -32768, 0, 0, 0);
    add_row(4095, 1, 16384, -16384, 0, 0, 0);
    add_row(4095, 31, 0, 0, 0, 0, 0);
    add_row(2048, 63, 32767, 32767, 0, 0, 0);
    add_row(1234, 10, 1, -1, 0, 0, 0);
    add_row(100, 32, -32768, 32767, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      gap = (i < 8) ? 0 : $urandom_range(0, MAX_IDLE);
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want, gap);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) tx_gapless = ($urandom_range(0, 3) == 0);
      if (n == 300) hold_req = 1'b1;
      if (n >= 300 && n < 420) tx_gapless = 1'b1;
      if (n == 650) begin
        // let the pipeline run dry before going on
        in_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        it.position   = POS_W'($urandom);
        it.pair_index = PAIR_W'($urandom);
        it.x_even     = X_W'($urandom);
        it.x_odd      = X_W'($urandom);
      end else if (sel < 8) begin
        case ($urandom_range(0, 2))
          0: it.position = '0;
          1: it.position = '1;
          default: it.position = POS_W'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0: it.pair_index = '0;
          1: it.pair_index = '1;
          default: it.pair_index = PAIR_W'($urandom);
        endcase
        it.x_even = pick_x();
        it.x_odd  = pick_x();
      end else if (sel == 8) begin
        it.position   = POS_W'($urandom_range(0, 15));
        it.pair_index = PAIR_W'($urandom_range(0, 7));
        it.x_even     = X_W'($urandom);
        it.x_odd      = X_W'($urandom);
      end else begin
        it.position   = POS_W'($urandom);
        it.pair_index = PAIR_W'($urandom);
        it.x_even     = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
        it.x_odd      = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
      end
      gap = tx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
      send_item(it, 1'b0, none, gap);
    end
    in_valid <= 1'b0;

    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += expected_pairs.size();

    $display("rope: %0d pairs rotated (%0d directed), %0d results compared, %0d saturated",
             items_sent, directed_rows.size(), results_seen, saturated_seen);
    $display("rope: random stalls on both sides, one output hold-off, one drain; %0d cycles",
             cycles);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
